>>> rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Field widths fixed by the stream format.
    localparam int CAP_W     = 16;
    localparam int OUT_LEN_W = 16;

    // Default counter width and capacity after reset.
    localparam int                 LENGTH_BITS_DEFAULT = 16;
    localparam logic [CAP_W-1:0]   CAP_RESET           = 16'd256;

    // Status and error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Characters that matter to the escape decoder.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control bytes produced by the simple escapes.
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // Top six bits of high and low surrogates.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Decoder modes.
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX1    = 3'd2,
        MODE_WANT_BS = 3'd3,
        MODE_WANT_U  = 3'd4,
        MODE_HEX2    = 3'd5
    } mode_t;

    // Decoder state apart from the written-byte counter.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] acc;
        logic [1:0]  cnt;
        logic [9:0]  hs;
        logic [1:0]  err;
    } st_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            has_status;
        logic [1:0]      status;
    } res_t;

    // UTF-8 encoding of one code point.
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } utf8_t;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Encode a code point of up to 21 bits as UTF-8, first byte in b[0].
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp <= 21'h7F) begin
            u.n    = 3'd1;
            u.b[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            u.n    = 3'd2;
            u.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            u.b[1] = 8'h80 | {2'b00, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            u.n    = 3'd3;
            u.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            u.b[1] = 8'h80 | {2'b00, cp[11:6]};
            u.b[2] = 8'h80 | {2'b00, cp[5:0]};
        end
        else begin
            u.n    = 3'd4;
            u.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            u.b[1] = 8'h80 | {2'b00, cp[17:12]};
            u.b[2] = 8'h80 | {2'b00, cp[11:6]};
            u.b[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jsu_ifs.sv
// Valid/ready channel interfaces for raw input, decoded output and configuration.
`default_nettype none

interface jsu_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, in_byte, byte_present, end_of_string, input ready);
    modport sink   (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [15:0] out_length;
    logic        last;

    modport source (output valid, out_byte, is_status, status, out_length, last,
                    input ready);
    modport sink   (input valid, out_byte, is_status, status, out_length, last,
                    output ready);
endinterface

interface jsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

>>> rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: input register, decoder, result serializer.
//
// Raw string body bytes enter on the raw channel and decoded bytes leave on the
// decoded channel, followed by one status transfer per string carrying the outcome
// and the final byte count. An item that causes at most one result is taken every
// cycle while the decoded channel is ready; an item that causes n results (up to
// four UTF-8 bytes plus the status) holds the output port until all n have left, as
// results leave one per ready cycle through a single result register. The first
// result of an item passes the input register, then the result register, and waits
// in the input register while the result register holds earlier results. The capacity
// register may be written at any time the block is idle and is ready on every cycle.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    jsu_raw_if.sink   raw,
    jsu_out_if.source decoded,
    jsu_cfg_if.sink   cfg
);

    localparam int CW = (LENGTH_BITS > jsu_pkg::OUT_LEN_W) ? LENGTH_BITS : jsu_pkg::OUT_LEN_W;

    logic [jsu_pkg::CAP_W-1:0] cap_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_end_reg;

    jsu_pkg::st_t           st_reg;
    jsu_pkg::st_t           st_next;
    logic [LENGTH_BITS-1:0] wc_reg;
    logic [LENGTH_BITS-1:0] wc_next;
    jsu_pkg::res_t          res;

    logic                   bun_valid_reg;
    jsu_pkg::res_t          bun_reg;
    logic [LENGTH_BITS-1:0] bun_base_reg;
    logic [2:0]             idx_reg;

    logic [2:0]             res_total;
    logic [2:0]             bun_total;
    logic                   out_last;
    logic                   out_fire;
    logic                   bun_free;
    logic                   advance;
    logic                   load;
    logic [LENGTH_BITS-1:0] out_len;
    logic [CW-1:0]          out_len_wide;

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= jsu_pkg::CAP_RESET;
        end
        else if (cfg.valid && cfg.ready) begin
            cap_reg <= cfg.capacity;
        end
    end

    // Decoder between the input register and the result register.
    jsu_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .st            (st_reg),
        .wc            (wc_reg),
        .in_byte       (in_byte_reg),
        .byte_present  (in_present_reg),
        .end_of_string (in_end_reg),
        .capacity      (cap_reg),
        .st_next       (st_next),
        .wc_next       (wc_next),
        .res           (res)
    );

    // Handshake between stages.
    assign res_total = res.nbytes + {2'b00, res.has_status};
    assign bun_total = bun_reg.nbytes + {2'b00, bun_reg.has_status};
    assign out_last  = (idx_reg == bun_total - 3'd1);
    assign out_fire  = decoded.valid && decoded.ready;
    assign bun_free  = !bun_valid_reg || (out_fire && out_last);
    assign advance   = in_valid_reg && (bun_free || res_total == 3'd0);
    assign load      = advance && res_total != 3'd0;
    assign raw.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (raw.ready) begin
            in_valid_reg <= raw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready) begin
            in_byte_reg    <= raw.in_byte;
            in_present_reg <= raw.byte_present;
            in_end_reg     <= raw.end_of_string;
        end
    end

    // Decoder state, updated when an item leaves the input register.
    // All-zero state is the normal mode with no error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '0;
            wc_reg <= '0;
        end
        else if (advance) begin
            st_reg <= st_next;
            wc_reg <= wc_next;
        end
    end

    // Result register and its serializer index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bun_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load) begin
            bun_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_fire) begin
            if (out_last) begin
                bun_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bun_reg      <= res;
            bun_base_reg <= wc_reg;
        end
    end

    // Output fields of the current result.
    assign out_len      = bun_base_reg + LENGTH_BITS'(idx_reg)
                          + LENGTH_BITS'(idx_reg < bun_reg.nbytes);
    assign out_len_wide = CW'(out_len);

    assign decoded.valid      = bun_valid_reg;
    assign decoded.is_status  = (idx_reg >= bun_reg.nbytes);
    assign decoded.out_byte   = decoded.is_status ? 8'h00 : bun_reg.bytes[idx_reg[1:0]];
    assign decoded.status     = decoded.is_status ? bun_reg.status : jsu_pkg::ERR_NONE;
    assign decoded.out_length = out_len_wide[jsu_pkg::OUT_LEN_W-1:0];
    assign decoded.last       = out_last;

    // A status result is always the last result of its item.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && decoded.is_status |-> decoded.last)
        else $error("status result not marked last");

    // The serializer index never runs past the results held.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bun_valid_reg |-> (idx_reg < bun_total))
        else $error("serializer index beyond results");

    // Closing a string leaves the decoder in its idle state with a zero count.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_end_reg |=> (st_reg.mode == jsu_pkg::MODE_NORMAL && wc_reg == '0
                                   && st_reg.err == jsu_pkg::ERR_NONE))
        else $error("state not cleared at end of string");

    // The first error of a string holds until the string ends.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.err != jsu_pkg::ERR_NONE && !(advance && in_end_reg)
        |=> st_reg.err == $past(st_reg.err))
        else $error("error code changed within a string");

    // No data is produced once an error is recorded.
    a_no_data_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        load && st_reg.err != jsu_pkg::ERR_NONE |-> res.nbytes == 3'd0)
        else $error("data produced after an error");

endmodule

`default_nettype wire

>>> rtl/jsu_decode.sv
// Combinational escape decoder: one input item against the current state.
`default_nettype none

module jsu_decode #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
    input  jsu_pkg::st_t             st,
    input  logic [LENGTH_BITS-1:0]   wc,
    input  logic [7:0]               in_byte,
    input  logic                     byte_present,
    input  logic                     end_of_string,
    input  logic [jsu_pkg::CAP_W-1:0] capacity,
    output jsu_pkg::st_t             st_next,
    output logic [LENGTH_BITS-1:0]   wc_next,
    output jsu_pkg::res_t            res
);

    // Width wide enough to compare count plus bytes against the capacity.
    localparam int CW = (LENGTH_BITS > jsu_pkg::CAP_W) ? LENGTH_BITS : jsu_pkg::CAP_W;
    localparam int SW = CW + 1;

    always_comb
    begin
        jsu_pkg::st_t  s;
        jsu_pkg::utf8_t u;
        logic [4:0]    hv;
        logic [15:0]   acc_new;
        logic [20:0]   cp;
        logic          want;
        logic [SW-1:0] sum;

        s       = st;
        u       = '0;
        want    = 1'b0;
        hv      = jsu_pkg::hex_nibble(in_byte);
        acc_new = {st.acc[11:0], hv[3:0]};
        cp      = '0;
        sum     = '0;
        wc_next = wc;
        res     = '0;

        // Byte handling, skipped once the string has an error.
        if (byte_present && st.err == jsu_pkg::ERR_NONE) begin
            unique case (st.mode)
                jsu_pkg::MODE_NORMAL:
                begin
                    if (in_byte == jsu_pkg::CH_BSLASH) begin
                        s.mode = jsu_pkg::MODE_ESC;
                    end
                    else begin
                        want   = 1'b1;
                        u.n    = 3'd1;
                        u.b[0] = in_byte;
                    end
                end
                jsu_pkg::MODE_ESC:
                begin
                    s.mode = jsu_pkg::MODE_NORMAL;
                    u.n    = 3'd1;
                    want   = 1'b1;
                    unique case (in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            u.b[0] = in_byte;
                        jsu_pkg::CH_B: u.b[0] = jsu_pkg::CTL_BS;
                        jsu_pkg::CH_F: u.b[0] = jsu_pkg::CTL_FF;
                        jsu_pkg::CH_N: u.b[0] = jsu_pkg::CTL_LF;
                        jsu_pkg::CH_R: u.b[0] = jsu_pkg::CTL_CR;
                        jsu_pkg::CH_T: u.b[0] = jsu_pkg::CTL_HT;
                        jsu_pkg::CH_U:
                        begin
                            want   = 1'b0;
                            s.mode = jsu_pkg::MODE_HEX1;
                            s.acc  = '0;
                            s.cnt  = '0;
                        end
                        default:
                        begin
                            want  = 1'b0;
                            s.err = jsu_pkg::ERR_MALFORMED;
                        end
                    endcase
                end
                jsu_pkg::MODE_WANT_BS:
                begin
                    if (in_byte == jsu_pkg::CH_BSLASH) begin
                        s.mode = jsu_pkg::MODE_WANT_U;
                    end
                    else begin
                        s.err = jsu_pkg::ERR_MALFORMED;
                    end
                end
                jsu_pkg::MODE_WANT_U:
                begin
                    if (in_byte == jsu_pkg::CH_U) begin
                        s.mode = jsu_pkg::MODE_HEX2;
                        s.acc  = '0;
                        s.cnt  = '0;
                    end
                    else begin
                        s.err = jsu_pkg::ERR_MALFORMED;
                    end
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2:
                begin
                    if (!hv[4]) begin
                        s.err = jsu_pkg::ERR_MALFORMED;
                    end
                    else begin
                        s.acc = acc_new;
                        if (st.cnt != 2'd3) begin
                            s.cnt = st.cnt + 2'd1;
                        end
                        else begin
                            // Fourth digit completes the code unit.
                            s.cnt  = '0;
                            s.mode = jsu_pkg::MODE_NORMAL;
                            if (st.mode == jsu_pkg::MODE_HEX1) begin
                                if (acc_new[15:10] == jsu_pkg::SURR_HIGH_TAG) begin
                                    s.hs   = acc_new[9:0];
                                    s.mode = jsu_pkg::MODE_WANT_BS;
                                end
                                else if (acc_new[15:10] == jsu_pkg::SURR_LOW_TAG) begin
                                    s.err = jsu_pkg::ERR_MALFORMED;
                                end
                                else begin
                                    cp   = {5'd0, acc_new};
                                    want = 1'b1;
                                end
                            end
                            else begin
                                if (acc_new[15:10] != jsu_pkg::SURR_LOW_TAG) begin
                                    s.err = jsu_pkg::ERR_MALFORMED;
                                end
                                else begin
                                    cp   = jsu_pkg::SUPP_BASE + {1'b0, st.hs, acc_new[9:0]};
                                    want = 1'b1;
                                end
                            end
                            if (want) begin
                                u = jsu_pkg::utf8_encode(cp);
                            end
                        end
                    end
                end
                default:
                begin
                    s.mode = jsu_pkg::MODE_NORMAL;
                end
            endcase

            // Room check: the whole character fits below capacity or none of it goes out.
            if (want) begin
                sum = SW'(wc) + SW'(u.n);
                if (sum >= SW'(capacity)) begin
                    s.err = jsu_pkg::ERR_OVERFLOW;
                end
                else begin
                    res.nbytes = u.n;
                    res.bytes  = u.b;
                    wc_next    = LENGTH_BITS'(sum);
                end
            end
        end

        // End of string: report status and return to the idle state.
        if (end_of_string) begin
            if (s.mode != jsu_pkg::MODE_NORMAL && s.err == jsu_pkg::ERR_NONE) begin
                s.err = jsu_pkg::ERR_MALFORMED;
            end
            res.has_status = 1'b1;
            res.status     = s.err;
            s          = '0;
            s.mode     = jsu_pkg::MODE_NORMAL;
            wc_next    = '0;
        end

        st_next = s;
    end

endmodule

`default_nettype wire

>>> bench/unescape_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the decoded byte stream of the unescaper and compares every transfer.
module unescape_checker (
    input  logic clk,
    input  logic rst_n,
    jsu_raw_if   raw,
    jsu_out_if   decoded,
    jsu_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);
    import jsu_pkg::*;

    // One decoded transfer as the block should produce it.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [1:0]  status;
        logic [15:0] out_length;
        logic        last;
    } decoded_item_t;

    decoded_item_t expected_q[$];

    // Predicted decoder state.
    logic [15:0] cap_limit;
    mode_t       mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  high_bits;
    logic [15:0] written;
    logic [1:0]  err_code;
    int          item_results;

    // Value of a hex digit character, or -1 if the character is not one.
    function automatic int nibble_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return int'(c) - 48;
        if (c inside {[8'h61:8'h66]}) return int'(c) - 87;
        if (c inside {[8'h41:8'h46]}) return int'(c) - 55;
        return -1;
    endfunction

    // Return to the state at the start of a string.
    task automatic clear_string();
        mode      = MODE_NORMAL;
        hex_acc   = '0;
        hex_cnt   = '0;
        high_bits = '0;
        written   = '0;
        err_code  = ERR_NONE;
    endtask

    // Only the first error of a string is kept.
    task automatic note_error(input logic [1:0] code);
        if (err_code == ERR_NONE) err_code = code;
    endtask

    task automatic push_result(input logic [7:0] b, input logic st, input logic [1:0] code);
        decoded_item_t r;
        r.out_byte   = b;
        r.is_status  = st;
        r.status     = code;
        r.out_length = written;
        r.last       = 1'b0;
        expected_q.push_back(r);
        item_results++;
    endtask

    // A character is written whole or, when it does not fit, not at all.
    task automatic write_chars(input logic [3:0][7:0] chars, input int n);
        if (int'(written) + n >= int'(cap_limit)) begin
            note_error(ERR_OVERFLOW);
        end
        else begin
            for (int i = 0; i < n; i++) begin
                written = written + 16'd1;
                push_result(chars[i], 1'b0, ERR_NONE);
            end
        end
    endtask

    // UTF-8 encoding of one code point, lead byte first.
    task automatic write_code_point(input logic [20:0] cp);
        logic [3:0][7:0] c;
        c = '0;
        if (cp < 21'h80) begin
            c[0] = cp[7:0];
            write_chars(c, 1);
        end
        else if (cp < 21'h800) begin
            c[0] = {3'b110, cp[10:6]};
            c[1] = {2'b10, cp[5:0]};
            write_chars(c, 2);
        end
        else if (cp < 21'h10000) begin
            c[0] = {4'b1110, cp[15:12]};
            c[1] = {2'b10, cp[11:6]};
            c[2] = {2'b10, cp[5:0]};
            write_chars(c, 3);
        end
        else begin
            c[0] = {5'b11110, cp[20:18]};
            c[1] = {2'b10, cp[17:12]};
            c[2] = {2'b10, cp[11:6]};
            c[3] = {2'b10, cp[5:0]};
            write_chars(c, 4);
        end
    endtask

    // Escape decoder for one body byte.
    task automatic decode_byte(input logic [7:0] c);
        logic [3:0][7:0] one;
        logic            simple;
        int              d;
        one    = '0;
        simple = 1'b1;
        case (mode)
            MODE_NORMAL: begin
                if (c == CH_BSLASH) begin
                    mode = MODE_ESC;
                end
                else begin
                    one[0] = c;
                    write_chars(one, 1);
                end
            end
            MODE_ESC: begin
                mode = MODE_NORMAL;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: one[0] = c;
                    CH_B: one[0] = CTL_BS;
                    CH_F: one[0] = CTL_FF;
                    CH_N: one[0] = CTL_LF;
                    CH_R: one[0] = CTL_CR;
                    CH_T: one[0] = CTL_HT;
                    CH_U: begin
                        mode    = MODE_HEX1;
                        hex_acc = '0;
                        hex_cnt = '0;
                        simple  = 1'b0;
                    end
                    default: begin
                        note_error(ERR_MALFORMED);
                        simple = 1'b0;
                    end
                endcase
                if (simple) write_chars(one, 1);
            end
            MODE_WANT_BS: begin
                if (c == CH_BSLASH) mode = MODE_WANT_U;
                else note_error(ERR_MALFORMED);
            end
            MODE_WANT_U: begin
                if (c == CH_U) begin
                    mode    = MODE_HEX2;
                    hex_acc = '0;
                    hex_cnt = '0;
                end
                else begin
                    note_error(ERR_MALFORMED);
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                d = nibble_of(c);
                if (d < 0) begin
                    note_error(ERR_MALFORMED);
                end
                else begin
                    hex_acc = {hex_acc[11:0], 4'(d)};
                    if (hex_cnt < 2'd3) begin
                        hex_cnt = hex_cnt + 2'd1;
                    end
                    else if (mode == MODE_HEX1) begin
                        // First unit: a high surrogate waits for its partner.
                        hex_cnt = '0;
                        mode    = MODE_NORMAL;
                        if (hex_acc inside {[16'hD800:16'hDBFF]}) begin
                            high_bits = hex_acc[9:0];
                            mode      = MODE_WANT_BS;
                        end
                        else if (hex_acc inside {[16'hDC00:16'hDFFF]}) begin
                            note_error(ERR_MALFORMED);
                        end
                        else begin
                            write_code_point({5'b0, hex_acc});
                        end
                    end
                    else begin
                        // Second unit must be a low surrogate.
                        hex_cnt = '0;
                        mode    = MODE_NORMAL;
                        if (hex_acc inside {[16'hDC00:16'hDFFF]}) begin
                            write_code_point(21'h10000 + {high_bits, hex_acc[9:0]});
                        end
                        else begin
                            note_error(ERR_MALFORMED);
                        end
                    end
                end
            end
            default: mode = MODE_NORMAL;
        endcase
    endtask

    // All results of one accepted input item, the final one marked last.
    task automatic predict_item(input logic [7:0] c, input logic present, input logic eos);
        decoded_item_t tail;
        item_results = 0;
        if (present && err_code == ERR_NONE) decode_byte(c);
        if (eos) begin
            if (mode != MODE_NORMAL) note_error(ERR_MALFORMED);
            push_result(8'h00, 1'b1, err_code);
            clear_string();
        end
        if (item_results > 0) begin
            tail      = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
        end
    endtask

    // Compare one output transfer with the oldest prediction.
    task automatic check_result();
        decoded_item_t oldest;
        if (expected_q.size() == 0) begin
            $error("unexpected output transfer: out_byte %0h is_status %0b",
                   decoded.out_byte, decoded.is_status);
            mismatches++;
        end
        else begin
            oldest = expected_q.pop_front();
            if (decoded.out_byte !== oldest.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", oldest.out_byte, decoded.out_byte);
                mismatches++;
            end
            if (decoded.is_status !== oldest.is_status) begin
                $error("is_status: expected %0b, actual %0b", oldest.is_status,
                       decoded.is_status);
                mismatches++;
            end
            if (decoded.status !== oldest.status) begin
                $error("status: expected %0d, actual %0d", oldest.status, decoded.status);
                mismatches++;
            end
            if (decoded.out_length !== oldest.out_length) begin
                $error("out_length: expected %0d, actual %0d", oldest.out_length,
                       decoded.out_length);
                mismatches++;
            end
            if (decoded.last !== oldest.last) begin
                $error("last: expected %0b, actual %0b", oldest.last, decoded.last);
                mismatches++;
            end
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_limit = CAP_RESET;
            clear_string();
            expected_q.delete();
            mismatches = 0;
        end
        else begin
            if (cfg.valid && cfg.ready) cap_limit = cfg.capacity;
            if (raw.valid && raw.ready) begin
                predict_item(raw.in_byte, raw.byte_present, raw.end_of_string);
            end
            if (decoded.valid && decoded.ready) check_result();
        end
        outstanding = expected_q.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the unescaper testbench: clock, reset, string stimulus, capacity phases and verdict.
module tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                               CH_F, CH_N, CH_R, CH_T};

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         outstanding;
    int         cycles = 0;
    bit         idling;
    int         stall_left;
    int         items_sent;
    logic [7:0] body_q[$];

    jsu_raw_if raw_ch ();
    jsu_out_if dec_ch ();
    jsu_cfg_if cfg_ch ();

    json_string_unescape_utf8 uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_ch),
        .decoded (dec_ch),
        .cfg     (cfg_ch)
    );

    unescape_checker decode_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw         (raw_ch),
        .decoded     (dec_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side stalls in random bursts, only while idling is set.
    initial
    begin
        dec_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                dec_ch.ready = 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 4) == 0) begin
                dec_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 8) - 1;
            end
            else begin
                dec_ch.ready = 1'b1;
            end
        end
    end

    // One transfer on the raw channel, possibly after an idle burst.
    task automatic send_item(input logic [7:0] b, input logic present, input logic eos);
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            raw_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        raw_ch.valid         = 1'b1;
        raw_ch.in_byte       = b;
        raw_ch.byte_present  = present;
        raw_ch.end_of_string = eos;
        do @(posedge clk); while (!raw_ch.ready);
        if (present || eos) items_sent++;
    endtask

    // Send the queued body, ending on its last byte or with a byte-less end item.
    task automatic send_string(input bit separate_end);
        int n;
        n = body_q.size();
        if (n == 0) separate_end = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(body_q[i], 1'b1, !separate_end && i == n - 1);
        end
        if (separate_end) send_item(8'($urandom), 1'b0, 1'b1);
        body_q.delete();
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic wait_drained();
        @(negedge clk);
        raw_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Capacity write; the caller has already drained the block.
    task automatic set_capacity(input logic [15:0] value);
        cfg_ch.valid    = 1'b1;
        cfg_ch.capacity = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endtask

    // Leading hex digits of a value, letters in random case.
    task automatic push_hex_digits(input logic [15:0] v, input int count);
        logic [3:0] nib;
        for (int i = 0; i < count; i++) begin
            nib = v[15 - 4 * i -: 4];
            if (nib < 4'd10) body_q.push_back(8'h30 + nib);
            else if ($urandom_range(0, 1) == 1) body_q.push_back(8'h37 + nib);
            else body_q.push_back(8'h57 + nib);
        end
    endtask

    task automatic push_hex_escape(input logic [15:0] v);
        body_q.push_back(CH_BSLASH);
        body_q.push_back(CH_U);
        push_hex_digits(v, 4);
    endtask

    // A well-formed piece of string body.
    task automatic push_good_token();
        int         kind;
        logic [7:0] b;
        logic [15:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BSLASH) body_q.push_back(CH_BSLASH);
            body_q.push_back(b);
        end
        else if (kind < 55) begin
            body_q.push_back(CH_BSLASH);
            body_q.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
        end
        else if (kind < 78) begin
            case ($urandom_range(0, 3))
                0: v = 16'($urandom_range(16'h0000, 16'h007F));
                1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
                default: v = 16'($urandom_range(16'hE000, 16'hFFFF));
            endcase
            push_hex_escape(v);
        end
        else begin
            push_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            push_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
    endtask

    // A malformed piece; cut is set when the string has to end right after it.
    task automatic push_bad_token(output bit cut);
        logic [7:0]  b;
        logic [15:0] high;
        cut  = 1'b0;
        high = 16'($urandom_range(16'hD800, 16'hDBFF));
        case ($urandom_range(0, 6))
            0: begin
                // Unknown escape letter.
                do b = 8'($urandom); while (b inside {ESC_LETTERS[0], ESC_LETTERS[1],
                    ESC_LETTERS[2], ESC_LETTERS[3], ESC_LETTERS[4], ESC_LETTERS[5],
                    ESC_LETTERS[6], ESC_LETTERS[7], CH_U});
                body_q.push_back(CH_BSLASH);
                body_q.push_back(b);
            end
            1: begin
                // Non-hex character inside a unicode escape.
                do b = 8'($urandom); while (b inside {[8'h30:8'h39], [8'h41:8'h46],
                                                        [8'h61:8'h66]});
                body_q.push_back(CH_BSLASH);
                body_q.push_back(CH_U);
                push_hex_digits(16'($urandom), $urandom_range(0, 3));
                body_q.push_back(b);
            end
            2: push_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            3: begin
                // High surrogate not followed by a backslash.
                do b = 8'($urandom); while (b == CH_BSLASH);
                push_hex_escape(high);
                body_q.push_back(b);
            end
            4: begin
                // High surrogate, backslash, then something other than u.
                do b = 8'($urandom); while (b == CH_U);
                push_hex_escape(high);
                body_q.push_back(CH_BSLASH);
                body_q.push_back(b);
            end
            5: begin
                // High surrogate paired with a unit that is not a low surrogate.
                push_hex_escape(high);
                if ($urandom_range(0, 1) == 1) begin
                    push_hex_escape(16'($urandom_range(16'h0000, 16'hDBFF)));
                end
                else begin
                    push_hex_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
                end
            end
            default: begin
                // The string stops in the middle of an escape.
                cut = 1'b1;
                case ($urandom_range(0, 3))
                    0: body_q.push_back(CH_BSLASH);
                    1: begin
                        body_q.push_back(CH_BSLASH);
                        body_q.push_back(CH_U);
                        push_hex_digits(16'($urandom), $urandom_range(0, 3));
                    end
                    2: begin
                        push_hex_escape(high);
                        if ($urandom_range(0, 1) == 1) body_q.push_back(CH_BSLASH);
                    end
                    default: begin
                        push_hex_escape(high);
                        body_q.push_back(CH_BSLASH);
                        body_q.push_back(CH_U);
                        push_hex_digits(16'($urandom), $urandom_range(0, 3));
                    end
                endcase
            end
        endcase
    endtask

    // Mostly well-formed strings; about one in four carries an error.
    task automatic run_random(input int target);
        int stop_at;
        bit cut;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            repeat ($urandom_range(0, 5)) push_good_token();
            if ($urandom_range(0, 3) == 0) begin
                push_bad_token(cut);
                if (!cut) repeat ($urandom_range(0, 2)) push_good_token();
            end
            send_string($urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        raw_ch.valid         = 1'b0;
        raw_ch.in_byte       = 8'h00;
        raw_ch.byte_present  = 1'b0;
        raw_ch.end_of_string = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.capacity      = 16'h0000;
        idling               = 1'b1;
        items_sent           = 0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings at the reset capacity.
        send_string(1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        send_string(1'b0);
        load_text("\\uD83D\\uDE00");
        send_string(1'b0);
        load_text("\\n\\q");
        send_string(1'b0);
        load_text("\\u12");
        send_string(1'b0);

        run_random(16);

        // Capacity sweep, each phase started from an idle block.
        wait_drained();
        set_capacity(16'hFFFF);
        run_random(16);
        wait_drained();
        set_capacity(16'h0000);
        run_random(10);
        wait_drained();
        set_capacity(16'h0001);
        run_random(10);
        wait_drained();
        set_capacity(16'($urandom_range(2, 24)));
        run_random(22);
        wait_drained();
        set_capacity(16'h0100);
        idling = 1'b0;
        run_random(26);

        wait_drained();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/jsu_pkg.sv
rtl/jsu_ifs.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_utf8.sv
bench/unescape_checker.sv
bench/tb.sv
